@@ src/fbed_pkg.sv @@
// shared types and constants for the float-to-byte error diffusion unit
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package fbed_pkg;

    localparam int unsigned EXP_W      = 8;
    localparam int unsigned MANT_W     = 23;
    localparam int unsigned PROD_W     = 32;   // 24-bit significand times 255
    localparam int          EXP_OFFSET = 150;  // bias plus mantissa bits
    localparam logic [EXP_W-1:0] EXP_SPECIAL = 8'hFF;
    localparam logic [7:0]  OUT_MAX    = 8'd255;
    localparam logic [7:0]  OUT_MIN    = 8'd0;

    // per-word control that travels alongside the scaled magnitude
    typedef struct packed {
        logic start;       // line start, residual back to one half
        logic neg;         // sign of the pixel
        logic special;     // nan or infinity, result clamped
        logic special_hi;  // clamp to the top for nan and +inf
    } t_item_ctl;

endpackage

@@ src/float_to_byte_error_diffusion_unit.sv @@
// top level of the float-to-byte error diffusion unit
// depends on fbed_pkg, fbed_scale and fbed_quant
`timescale 1ns / 1ps

// Usage:
//   input channel: i_valid / o_stall with i_pixel_bits (ieee single) and
//   i_line_start; a word is taken on an edge where i_valid is high and
//   o_stall is low. output channel: o_valid / i_stall with o_out_byte.
//   each word gives exactly one byte, in order. pixels of a line run
//   left to right; i_line_start sets the carried error back to one half
//   before that pixel is used.
//   pipeline: input register, scale stage (float to fixed point times 255),
//   quantize stage (residual add, clamp, output register). a word goes from
//   the input register to the scale register, then to the output register.
//   throughput is one word per cycle while i_stall is low, set by the residual
//   add-and-clamp loop in the quantize stage.
//   when i_stall is high the output word holds; the stages behind it keep
//   filling until the input register is occupied, then o_stall rises.
//   synchronous reset (i_rst_n low) empties every stage and sets the
//   residual to one half.

module float_to_byte_error_diffusion_unit #(
    parameter int FRACTION_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [31:0] i_pixel_bits,
    input  logic        i_line_start,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_out_byte
);
    import fbed_pkg::*;

    localparam int MW = FRACTION_BITS + 9;

    logic          r_a_valid;
    logic          n_a_valid;
    logic [31:0]   r_a_bits;
    logic          r_a_start;

    logic          b_valid;
    t_item_ctl     b_ctl;
    logic [MW-1:0] b_mag;
    logic          q_take;
    logic          b_free;
    logic          a_free;
    logic          accept;

    always_comb begin
        b_free    = !b_valid || q_take;
        a_free    = !r_a_valid || b_free;
        accept    = i_valid && a_free;
        n_a_valid = a_free ? i_valid : r_a_valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else begin
            r_a_valid <= n_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_a_bits  <= i_pixel_bits;
            r_a_start <= i_line_start;
        end
    end

    fbed_scale #(
        .FRACTION_BITS(FRACTION_BITS)
    ) u_scale (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (b_free),
        .i_valid      (r_a_valid),
        .i_pixel_bits (r_a_bits),
        .i_line_start (r_a_start),
        .o_valid      (b_valid),
        .o_ctl        (b_ctl),
        .o_mag        (b_mag)
    );

    fbed_quant #(
        .FRACTION_BITS(FRACTION_BITS)
    ) u_quant (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_stall    (i_stall),
        .i_valid    (b_valid),
        .i_ctl      (b_ctl),
        .i_mag      (b_mag),
        .o_take     (q_take),
        .o_valid    (o_valid),
        .o_out_byte (o_out_byte)
    );

    assign o_stall = !a_free;

    // a word blocked in the input register is neither lost nor altered
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_a_valid && !b_free) |=> (r_a_valid && $stable(r_a_bits)))
        else $error("input register word lost while blocked");

endmodule

@@ src/fbed_scale.sv @@
// stage b: turns the raw float into a sign-magnitude fixed-point value times 255
// depends on fbed_pkg
`timescale 1ns / 1ps

module fbed_scale #(
    parameter int FRACTION_BITS = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_en,
    input  logic                     i_valid,
    input  logic [31:0]              i_pixel_bits,
    input  logic                     i_line_start,
    output logic                     o_valid,
    output fbed_pkg::t_item_ctl      o_ctl,
    output logic [FRACTION_BITS+8:0] o_mag
);
    import fbed_pkg::*;

    localparam int MW = FRACTION_BITS + 9;
    localparam logic [63:0] CAP = 64'd256 << FRACTION_BITS;
    localparam logic signed [9:0] SH_OFS = 10'(FRACTION_BITS - EXP_OFFSET);

    logic [EXP_W-1:0]  ex;
    logic [MANT_W-1:0] fr;
    logic [MANT_W:0]   mant;
    logic [PROD_W-1:0] m;
    logic [EXP_W-1:0]  ex_eff;
    logic signed [9:0] sh;
    logic signed [9:0] amt;
    logic [63:0]       p;
    logic [63:0]       p_cap;
    t_item_ctl         ctl;

    logic              r_valid;
    logic              n_valid;
    t_item_ctl         r_ctl;
    logic [MW-1:0]     r_mag;

    always_comb begin
        ex     = i_pixel_bits[30:23];
        fr     = i_pixel_bits[22:0];
        mant   = (ex == '0) ? {1'b0, fr} : {1'b1, fr};
        // times 255 as a shift and subtract
        m      = ({8'd0, mant} << 8) - {8'd0, mant};
        ex_eff = (ex == '0) ? EXP_W'(1) : ex;
        sh     = signed'({2'b00, ex_eff}) + SH_OFS;
        amt    = -sh;
        if (sh > 10'sd31) begin
            p = (m != '0) ? CAP : 64'd0;
        end else if (sh >= 10'sd0) begin
            p = {32'd0, m} << sh[4:0];
        end else if (amt > 10'sd31) begin
            p = 64'd0;
        end else begin
            p = {32'd0, m >> amt[4:0]};
        end
        p_cap = (p > CAP) ? CAP : p;

        ctl.start      = i_line_start;
        ctl.neg        = i_pixel_bits[31];
        ctl.special    = (ex == EXP_SPECIAL);
        ctl.special_hi = (fr != '0) || !i_pixel_bits[31];
        n_valid        = i_en ? i_valid : r_valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en && i_valid) begin
            r_ctl <= ctl;
            r_mag <= p_cap[MW-1:0];
        end
    end

    assign o_valid = r_valid;
    assign o_ctl   = r_ctl;
    assign o_mag   = r_mag;

endmodule

@@ src/fbed_quant.sv @@
// output stage: adds the carried residual, clamps and quantizes to a byte
// depends on fbed_pkg; holds the residual and the output register
`timescale 1ns / 1ps

module fbed_quant #(
    parameter int FRACTION_BITS = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_stall,
    input  logic                     i_valid,
    input  fbed_pkg::t_item_ctl      i_ctl,
    input  logic [FRACTION_BITS+8:0] i_mag,
    output logic                     o_take,
    output logic                     o_valid,
    output logic [7:0]               o_out_byte
);
    import fbed_pkg::*;

    localparam int GW = FRACTION_BITS + 10;
    localparam logic [FRACTION_BITS-1:0] HALF = FRACTION_BITS'(1) << (FRACTION_BITS - 1);
    localparam logic [GW-2:0] TOP = (GW-1)'(255) << FRACTION_BITS;

    logic                     take;
    logic                     load;
    logic [FRACTION_BITS-1:0] base;
    logic signed [GW-1:0]     base_ext;
    logic signed [GW-1:0]     mag_ext;
    logic signed [GW-1:0]     g;

    logic [FRACTION_BITS-1:0] r_res;
    logic [FRACTION_BITS-1:0] n_res;
    logic                     r_o_valid;
    logic                     n_o_valid;
    logic [7:0]               r_o_byte;
    logic [7:0]               n_o_byte;

    always_comb begin
        take     = !r_o_valid || !i_stall;
        load     = take && i_valid;
        base     = i_ctl.start ? HALF : r_res;
        base_ext = signed'({10'd0, base});
        mag_ext  = signed'({1'b0, i_mag});
        g        = i_ctl.neg ? (base_ext - mag_ext) : (base_ext + mag_ext);

        n_res    = base;
        if (i_ctl.special) begin
            n_o_byte = i_ctl.special_hi ? OUT_MAX : OUT_MIN;
        end else if (g <= 0) begin
            n_o_byte = OUT_MIN;
        end else if (g[GW-2:0] >= TOP) begin
            n_o_byte = OUT_MAX;
        end else begin
            n_o_byte = g[FRACTION_BITS+7:FRACTION_BITS];
            n_res    = g[FRACTION_BITS-1:0];
        end
        n_o_valid = take ? i_valid : r_o_valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res     <= HALF;
            r_o_valid <= 1'b0;
        end else begin
            r_o_valid <= n_o_valid;
            if (load) begin
                r_res <= n_res;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_o_byte <= n_o_byte;
        end
    end

    assign o_take     = take;
    assign o_valid    = r_o_valid;
    assign o_out_byte = r_o_byte;

    // residual moves only when a word enters the output register
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !load |=> $stable(r_res))
        else $error("residual changed without a word");

    // nan or infinity words at a line start leave the residual at one half
    a_res_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (load && i_ctl.start && i_ctl.special) |=> (r_res == HALF))
        else $error("line start did not reset residual");

    // nan and +inf give the top code
    a_special_hi: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (load && i_ctl.special && i_ctl.special_hi) |=> (r_o_byte == OUT_MAX))
        else $error("special value not clamped high");

endmodule
